// ----- rtl/lucs_pkg.sv -----
`default_nettype none

package lucs_pkg;

	// Width of every size, limit and gap field on the ports.
	localparam int FIELD_W = 12;

	// Number of part sizes in one problem.
	localparam int SIZE_COUNT = 4;
	localparam int SIZE_IDX_W = $clog2(SIZE_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SELECT,
		ST_SWEEP,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_FINISH
	} lucs_state_t;

endpackage

`default_nettype wire

// ----- rtl/lucs_bitmem.sv -----
`default_nettype none

// Single-bit store with one write port and one registered read port.
// A read of the entry being written in the same cycle returns the old bit.
module lucs_bitmem #(
	parameter int DEPTH = 4096,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/largest_unreachable_coin_sum_core.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    size_first..size_fourth, upper_limit
// output    out        out_valid/out_stall  largest_gap, all_reachable
//
// One problem is processed at a time. With L the limit (saturated to
// MAX_TOTAL - 1), the store handles one entry per cycle in the clear pass
// over totals 0 .. L, in each upward sweep and in the downward scan; its
// single read port and single write port set that pace. Reset clears only
// control state; the store is rewritten by each item before it is read. A
// stalled result sits in the output register while the next transaction
// may already be accepted and worked on.
module largest_unreachable_coin_sum_core
	import lucs_pkg::*;
#(
	parameter int MAX_TOTAL = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FIELD_W-1:0] size_first,
	input  wire logic [FIELD_W-1:0] size_second,
	input  wire logic [FIELD_W-1:0] size_third,
	input  wire logic [FIELD_W-1:0] size_fourth,
	input  wire logic [FIELD_W-1:0] upper_limit,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      largest_gap,
	output logic                    all_reachable
);

	// Address width of the store and a compare width that covers both the
	// store addresses and the port fields.
	localparam int AW = $clog2(MAX_TOTAL);
	localparam int CW = (AW > FIELD_W) ? AW : FIELD_W;
	localparam logic [SIZE_IDX_W-1:0] LAST_SIZE = SIZE_IDX_W'(SIZE_COUNT - 1);

	// One read in flight: the entry it serves, whether it belongs to the
	// scan, and whether the bit was being set in the cycle the read issued.
	typedef struct packed {
		logic          valid;
		logic          is_scan;
		logic [AW-1:0] tgt;
		logic          fwd;
	} pipe_t;

	lucs_state_t state_q, state_d;

	logic [FIELD_W-1:0]    size_q [SIZE_COUNT];
	logic [AW-1:0]         lim_q;
	logic [AW-1:0]         t_q;
	logic [AW-1:0]         s_q;
	logic [SIZE_IDX_W-1:0] k_q;
	pipe_t                 pipe_s1;
	logic [AW-1:0]         gap_q;
	logic                  all_q;
	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_gap_q;
	logic                  out_all_q;

	logic          issue;
	logic          issue_scan;
	logic          load_out;
	logic [AW-1:0] rd_addr;
	logic          rd_data_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;

	// The limit saturates to the top of the store.
	logic [CW-1:0] lim_ext;
	logic [CW-1:0] lim_sat;
	assign lim_ext = CW'(upper_limit);
	assign lim_sat = (lim_ext > CW'(MAX_TOTAL - 1)) ? CW'(MAX_TOTAL - 1) : lim_ext;

	// A size of zero or one above the limit contributes nothing.
	logic [CW-1:0] size_ext;
	logic          size_skip;
	assign size_ext  = CW'(size_q[k_q]);
	assign size_skip = (size_ext == '0) || (size_ext > CW'(lim_q));

	// Read data, with a set that landed in the read's own cycle folded in.
	logic eff_rd;
	logic sweep_wr;
	logic resolve;
	assign eff_rd   = rd_data_s1 | pipe_s1.fwd;
	assign sweep_wr = pipe_s1.valid && !pipe_s1.is_scan && eff_rd;
	assign resolve  = pipe_s1.valid && pipe_s1.is_scan && (!eff_rd || (pipe_s1.tgt == '0));

	lucs_bitmem #(
		.DEPTH(MAX_TOTAL),
		.AW   (AW)
	) u_bitmem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data_s1)
	);

	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		issue_scan = 1'b0;
		load_out   = 1'b0;
		rd_addr    = t_q;
		// Sweep results are written back in the cycle after their read issued.
		wr_en      = sweep_wr;
		wr_addr    = pipe_s1.tgt;
		wr_data    = 1'b1;
		in_stall   = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				// Total zero is the only one reachable before any size is used.
				wr_en   = 1'b1;
				wr_addr = t_q;
				wr_data = (t_q == '0);
				if (t_q == lim_q) begin
					state_d = ST_SELECT;
				end
			end
			ST_SELECT: begin
				if (!size_skip) begin
					state_d = ST_SWEEP;
				end else if (k_q == LAST_SIZE) begin
					state_d = ST_SCAN;
				end
			end
			ST_SWEEP: begin
				issue   = 1'b1;
				rd_addr = t_q - s_q;
				if (t_q == lim_q) begin
					state_d = (k_q == LAST_SIZE) ? ST_SCAN : ST_SELECT;
				end
			end
			ST_SCAN: begin
				issue      = 1'b1;
				issue_scan = 1'b1;
				if (resolve) begin
					state_d = ST_FINISH;
				end else if (t_q == '0) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: begin
				if (resolve) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pipe_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q         <= state_d;
			// A read issued in the cycle the scan resolves is dropped.
			pipe_s1.valid   <= issue && !resolve;
			pipe_s1.is_scan <= issue_scan;
			pipe_s1.tgt     <= t_q;
			pipe_s1.fwd     <= wr_en && wr_data && (wr_addr == rd_addr);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Problem registers, counters and results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					size_q[0] <= size_first;
					size_q[1] <= size_second;
					size_q[2] <= size_third;
					size_q[3] <= size_fourth;
					lim_q     <= lim_sat[AW-1:0];
					t_q       <= '0;
					k_q       <= '0;
				end
			end
			ST_CLEAR: begin
				t_q <= t_q + 1'b1;
			end
			ST_SELECT: begin
				if (!size_skip) begin
					s_q <= size_ext[AW-1:0];
					t_q <= size_ext[AW-1:0];
				end else begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_SIZE) begin
						t_q <= lim_q;
					end
				end
			end
			ST_SWEEP: begin
				t_q <= t_q + 1'b1;
				if (t_q == lim_q) begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_SIZE) begin
						t_q <= lim_q;
					end
				end
			end
			ST_SCAN: begin
				t_q <= t_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (resolve) begin
			all_q <= eff_rd;
			gap_q <= eff_rd ? '0 : pipe_s1.tgt;
		end
		if (load_out) begin
			out_gap_q <= FIELD_W'(gap_q);
			out_all_q <= all_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign largest_gap   = out_gap_q;
	assign all_reachable = out_all_q;

endmodule

`default_nettype wire

// ----- tb/tb_largest_unreachable_coin_sum_core.sv -----
`timescale 1ns / 100ps

module tb_largest_unreachable_coin_sum_core;
	import lucs_pkg::*;

	// The store in the block holds totals 0 .. STORE_DEPTH - 1. Any limit beyond
	// that saturates, although a 12-bit limit never gets there at the default depth.
	localparam int STORE_DEPTH = 4096;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_PROBLEMS = 100;
	// One long output hold-off, long enough for many small problems to back up.
	localparam int LONG_HOLD_CYCLES = 400;
	// Every problem yields exactly one transaction, so after the last one only a
	// short quiet window is needed to catch anything spurious.
	localparam int DRAIN_CYCLES = 64;
	// The slowest correct run puts every problem at the largest limit with four
	// usable sizes, plus the worst stalls and gaps.
	// Take that several times over.
	localparam int CYCLE_LIMIT = 12_000_000;

	typedef struct {
		logic [FIELD_W-1:0] gap;
		logic               all_ok;
	} gap_result_t;

	// Holds the expected answers of the problems in flight. It keeps its own
	// reachability bits and solves every accepted problem as it comes in.
	class gap_scoreboard;
		gap_result_t expected_q[$];
		bit          reach[STORE_DEPTH];
		int          errors;
		int          problems;
		int          results;
		int          full_cover;
		int          widest_limit;

		function gap_result_t solve_gap(logic [FIELD_W-1:0] sizes[SIZE_COUNT],
				logic [FIELD_W-1:0] limit_in);
			gap_result_t r;
			int lim;
			int s;
			lim = (limit_in > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : int'(limit_in);
			for (int t = 0; t <= lim; t++)
				reach[t] = 1'b0;
			reach[0] = 1'b1;
			for (int k = 0; k < SIZE_COUNT; k++) begin
				s = sizes[k];
				if (s == 0 || s > lim)
					continue;
				for (int t = s; t <= lim; t++)
					if (reach[t - s])
						reach[t] = 1'b1;
			end
			r.gap = '0;
			r.all_ok = 1'b1;
			for (int t = lim; t >= 0; t--) begin
				if (!reach[t]) begin
					r.gap = t[FIELD_W-1:0];
					r.all_ok = 1'b0;
					break;
				end
			end
			return r;
		endfunction

		function void note_problem(logic [FIELD_W-1:0] s0, logic [FIELD_W-1:0] s1,
				logic [FIELD_W-1:0] s2, logic [FIELD_W-1:0] s3, logic [FIELD_W-1:0] lim);
			logic [FIELD_W-1:0] sizes[SIZE_COUNT];
			gap_result_t r;
			sizes[0] = s0;
			sizes[1] = s1;
			sizes[2] = s2;
			sizes[3] = s3;
			r = solve_gap(sizes, lim);
			expected_q.push_back(r);
			problems++;
			if (r.all_ok)
				full_cover++;
			if (lim > widest_limit)
				widest_limit = lim;
		endfunction

		function void check_result(logic [FIELD_W-1:0] gap, logic all_ok);
			gap_result_t r;
			results++;
			if (expected_q.size() == 0) begin
				$error("result with no problem pending: largest_gap=%0d all_reachable=%0b",
					gap, all_ok);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (gap !== r.gap) begin
				$error("largest_gap: expected %0d, actual %0d", r.gap, gap);
				errors++;
			end
			if (all_ok !== r.all_ok) begin
				$error("all_reachable: expected %0b, actual %0b", r.all_ok, all_ok);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [FIELD_W-1:0] size_first = '0;
	logic [FIELD_W-1:0] size_second = '0;
	logic [FIELD_W-1:0] size_third = '0;
	logic [FIELD_W-1:0] size_fourth = '0;
	logic [FIELD_W-1:0] upper_limit = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FIELD_W-1:0] largest_gap;
	logic               all_reachable;

	gap_scoreboard sb = new();

	// When set, both sides skip their random waits so back-to-back transactions
	// are exercised as well.
	bit free_run = 1'b0;
	// Raised by the stimulus to ask the result side for one long hold-off.
	bit long_hold_req = 1'b0;
	int long_holds = 0;
	int cycle_count = 0;

	largest_unreachable_coin_sum_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.size_first    (size_first),
		.size_second   (size_second),
		.size_third    (size_third),
		.size_fourth   (size_fourth),
		.upper_limit   (upper_limit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.largest_gap   (largest_gap),
		.all_reachable (all_reachable)
	);

	always #CLK_HALF clk = ~clk;

	// The run must not hang: a stuck handshake ends it here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Both monitors sample at the rising edge. All block outputs and all of our
	// inputs change by nonblocking assignment, so the values seen here are the
	// ones that were present just before the edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_problem(size_first, size_second, size_third, size_fourth, upper_limit);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(largest_gap, all_reachable);
	end

	// Result side. Before each transaction it may hold off at random, or hold
	// off for one long stretch when the stimulus asks for it. During that stretch
	// the block keeps its finished result and, after the next problem, has to
	// stall its input.
	initial begin : result_sink
		int hold;
		forever begin
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				long_holds++;
			end else begin
				hold = free_run ? 0 : $urandom_range(0, 3);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one problem and returns at the edge where it was taken. The valid
	// is only lowered when a gap follows, so a back-to-back transaction never
	// sees valid dropped and raised in the same step.
	task automatic send_problem(input logic [FIELD_W-1:0] s0, input logic [FIELD_W-1:0] s1,
			input logic [FIELD_W-1:0] s2, input logic [FIELD_W-1:0] s3,
			input logic [FIELD_W-1:0] lim);
		int idle;
		idle = free_run ? 0 : $urandom_range(0, 3);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid    <= 1'b1;
		size_first  <= s0;
		size_second <= s1;
		size_third  <= s2;
		size_fourth <= s3;
		upper_limit <= lim;
		do @(posedge clk); while (in_stall);
	endtask

	// Picks one part size for a given limit. Most sizes fall inside the limit,
	// some are zero and some are full-width noise that mostly lands above it.
	function automatic logic [FIELD_W-1:0] pick_size(int lim);
		int c;
		c = $urandom_range(0, 9);
		if (c == 0)
			return '0;
		if (c == 1)
			return FIELD_W'($urandom());
		return FIELD_W'($urandom_range(1, (lim + 1 > 4095) ? 4095 : lim + 1));
	endfunction

	initial begin : stimulus
		int lim;
		int pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed problems. A limit of zero is always fully covered, whatever
		// the sizes are.
		send_problem(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_problem(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0);
		// Largest limit with no usable size: every total but zero is a gap.
		send_problem(12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF);
		// Sizes equal to the limit only reach the limit itself.
		send_problem(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		// A unit size covers everything up to the largest limit.
		send_problem(12'd1, 12'd0, 12'd0, 12'd0, 12'hFFF);
		// Classic case with the largest gap at 43, one size equal to the limit
		// still being used.
		send_problem(12'd6, 12'd9, 12'd20, 12'hFFF, 12'hFFF);
		send_problem(12'd6, 12'd9, 12'd20, 12'd0, 12'd100);
		send_problem(12'd3, 12'd5, 12'd0, 12'd0, 12'd10);
		// Only even sizes: the largest odd total stays a gap.
		send_problem(12'd2, 12'd4, 12'd6, 12'd8, 12'd12);
		send_problem(12'd1, 12'd0, 12'd0, 12'd0, 12'd1);
		send_problem(12'd2, 12'd3, 12'd4, 12'd5, 12'd1);
		// Every size above the limit: the limit itself is the gap.
		send_problem(12'd51, 12'd60, 12'hFFF, 12'd100, 12'd50);
		send_problem(12'd30, 12'd0, 12'd0, 12'd0, 12'd30);
		send_problem(12'd5, 12'd5, 12'd5, 12'd5, 12'd20);
		send_problem(12'd7, 12'd6, 12'd5, 12'd4, 12'd7);
		// Alternating bit patterns on sizes and limit.
		send_problem(12'h555, 12'hAAA, 12'h007, 12'hFFF, 12'hAAA);
		send_problem(12'hAAA, 12'h555, 12'h00B, 12'h003, 12'h555);
		send_problem(12'd4095, 12'd1, 12'd0, 12'd2, 12'd4094);

		// Random problems. Most limits are small to keep the run short; a few
		// go to the top of the range. Items 30 to 49 run with no idling on
		// either side, and around item 60 the result side holds off for a long
		// stretch while a burst of tiny problems keeps coming.
		for (int i = 0; i < RANDOM_PROBLEMS; i++) begin
			if (i == 30)
				free_run = 1'b1;
			if (i == 50)
				free_run = 1'b0;
			if (i == 60)
				long_hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (i >= 60 && i < 70)
				lim = $urandom_range(0, 15);
			else if (pick < 3)
				lim = $urandom_range(1000, 4095);
			else if (pick < 18)
				lim = $urandom_range(64, 400);
			else
				lim = $urandom_range(0, 63);
			if (pick < 3)
				send_problem(FIELD_W'($urandom_range(1, 64)), FIELD_W'($urandom_range(1, 64)),
					FIELD_W'($urandom_range(1, 64)), pick_size(lim), lim[FIELD_W-1:0]);
			else
				send_problem(pick_size(lim), pick_size(lim), pick_size(lim),
					pick_size(lim), lim[FIELD_W-1:0]);
		end
		in_valid <= 1'b0;

		// Let every problem come back, then watch a while for anything extra.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Solved %0d problems with limits up to %0d; %0d results checked, %0d fully covered.",
			sb.problems, sb.widest_limit, sb.results, sb.full_cover);
		$display("Random idling on both sides, a back-to-back stretch and %0d long output hold-off.",
			long_holds);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lucs_pkg.sv
rtl/lucs_bitmem.sv
rtl/largest_unreachable_coin_sum_core.sv
tb/tb_largest_unreachable_coin_sum_core.sv
